FILE: hdl/fbpa_pkg.sv
// Shared types and constants of the fixed block pool allocator.
// Used by the top level, the divider and the testbench; depends on nothing else.
`default_nettype none

package fbpa_pkg;

	localparam int ADDR_W   = 32;
	localparam int BASE_W   = 32;
	localparam int BYTES_W  = 17;
	localparam int COUNT_W  = 7;
	localparam int SIZE_W   = BYTES_W + 1;
	localparam int SPAN_W   = SIZE_W + COUNT_W;
	localparam int QUOT_W   = COUNT_W;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NULL    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd2;

	localparam logic [BASE_W-1:0]  RST_POOL_BASE   = 32'd0;
	localparam logic [BYTES_W-1:0] RST_BLOCK_BYTES = 17'd4;
	localparam logic [COUNT_W-1:0] RST_BLOCK_COUNT = 7'd64;

	typedef struct packed {
		logic              operation;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   block_address;
		logic [COUNT_W-1:0]  free_blocks;
	} rsp_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
		logic              rem_zero;
	} div_res_t;

endpackage

`default_nettype wire

FILE: hdl/fixed_block_pool_allocator_top.sv
// Fixed block pool allocator: LIFO free list with double-free detection.
// Allocate: the request passes through the span, check, decide and alloc states. Free: the
// span, check and decide states, then the 7-step divider and the list walk through the link
// RAM read port; failed checks end sooner. A held-off response keeps the block in its final
// state, and the next request can be accepted in the same cycle as the result issues.
// Reset restores the register defaults and the free list 0, 1, 2, ... at once.
`default_nettype none

module fixed_block_pool_allocator_top #(
	parameter int MAX_BLOCKS = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_stall,
	input  wire fbpa_pkg::req_t                    req,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output fbpa_pkg::rsp_t                         rsp,
	input  wire logic                              cfg_write,
	input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int LW = $clog2(MAX_BLOCKS + 1);
	localparam int AW = fbpa_pkg::ADDR_W;
	localparam int NW = fbpa_pkg::COUNT_W;
	localparam int ZW = fbpa_pkg::SIZE_W;
	localparam int SW = fbpa_pkg::SPAN_W;
	localparam logic [NW-1:0] RST_FREE =
		(int'(fbpa_pkg::RST_BLOCK_COUNT) > MAX_BLOCKS) ? NW'(MAX_BLOCKS)
		                                               : fbpa_pkg::RST_BLOCK_COUNT;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SPAN   = 4'd1;
	localparam logic [3:0] S_CHECK  = 4'd2;
	localparam logic [3:0] S_DECIDE = 4'd3;
	localparam logic [3:0] S_ALLOC  = 4'd4;
	localparam logic [3:0] S_DIV    = 4'd5;
	localparam logic [3:0] S_WALK   = 4'd6;
	localparam logic [3:0] S_FIN    = 4'd7;

	logic [3:0]                      state_q;
	logic [fbpa_pkg::BASE_W-1:0]     base_q;
	logic [fbpa_pkg::BYTES_W-1:0]    bytes_q;
	logic [NW-1:0]                   count_q;
	logic [LW-1:0]                   head_q;
	logic [NW-1:0]                   free_q;
	logic [LW-1:0]                   mark_q;
	logic                            op_q;
	logic [AW-1:0]                   addr_q;
	logic [SW-1:0]                   span_q;
	logic                            valid_q;
	logic [AW-1:0]                   diff_q;
	logic                            below_q;
	logic [LW+ZW-1:0]                prod_q;
	logic [fbpa_pkg::QUOT_W-1:0]     idx_q;
	logic [LW-1:0]                   cur_q;
	logic [NW-1:0]                   walk_q;
	logic [fbpa_pkg::STATUS_W-1:0]   status_q;
	logic [AW-1:0]                   result_q;
	logic                            rsp_valid_q;
	fbpa_pkg::rsp_t                  rsp_q;

	logic [ZW-1:0]                   size;
	logic [NW-1:0]                   cnt_eff;
	logic [NW-1:0]                   cnt_new;
	logic [AW:0]                     top_sum;
	logic [AW:0]                     sub_res;
	logic [LW-1:0]                   link_val;
	logic [LW-1:0]                   cur_next;
	logic [LW-1:0]                   idx_l;
	logic [LW-1:0]                   ram_rdata;
	logic [IW-1:0]                   ram_raddr;
	logic                            ram_we;
	logic                            div_start;
	fbpa_pkg::div_res_t              div_res;
	logic                            out_free;

	assign size     = (ZW'(bytes_q) + ZW'(3)) & ~ZW'(3);
	assign cnt_eff  = (int'(count_q) > MAX_BLOCKS) ? NW'(MAX_BLOCKS) : count_q;
	assign cnt_new  = (int'(cfg_data[NW-1:0]) > MAX_BLOCKS) ? NW'(MAX_BLOCKS)
	                                                        : cfg_data[NW-1:0];
	assign top_sum  = {1'b0, base_q} + (AW+1)'(span_q);
	assign sub_res  = {1'b0, addr_q} - {1'b0, base_q};
	assign link_val = (head_q >= mark_q) ? head_q + LW'(1) : ram_rdata;
	assign cur_next = (cur_q >= mark_q) ? cur_q + LW'(1) : ram_rdata;
	assign idx_l    = LW'(idx_q);
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign ram_raddr = (state_q == S_WALK) ? cur_next[IW-1:0] : head_q[IW-1:0];
	assign ram_we    = (state_q == S_WALK) && (walk_q == free_q);
	assign div_start = (state_q == S_DECIDE) && (op_q == fbpa_pkg::OP_FREE);

	fbpa_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_BLOCKS)
	) u_links (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_l[IW-1:0]),
		.wdata (head_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fbpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff_q[SW-1:0]),
		.divisor  (size),
		.res      (div_res)
	);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q   <= req.operation;
				addr_q <= req.address;
			end
			S_SPAN: begin
				span_q <= SW'(size) * SW'(cnt_eff);
			end
			S_CHECK: begin
				valid_q <= (base_q != '0) && (base_q[1:0] == 2'b00) && (size != '0) &&
				           !top_sum[AW];
				diff_q  <= sub_res[AW-1:0];
				below_q <= sub_res[AW];
			end
			S_DECIDE: begin
				prod_q <= (LW+ZW)'(head_q) * (LW+ZW)'(size);
			end
			S_DIV: begin
				idx_q <= div_res.quot;
			end
			default: begin
			end
		endcase
		if (state_q == S_FIN && out_free) begin
			rsp_q.status        <= status_q;
			rsp_q.block_address <= result_q;
			rsp_q.free_blocks   <= free_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= fbpa_pkg::RST_POOL_BASE;
			bytes_q     <= fbpa_pkg::RST_BLOCK_BYTES;
			count_q     <= fbpa_pkg::RST_BLOCK_COUNT;
			head_q      <= '0;
			free_q      <= RST_FREE;
			mark_q      <= '0;
			cur_q       <= '0;
			walk_q      <= '0;
			status_q    <= fbpa_pkg::ST_OK;
			result_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_write && cfg_index <= fbpa_pkg::REG_BLOCK_COUNT) begin
				unique case (cfg_index)
					fbpa_pkg::REG_POOL_BASE: begin
						base_q <= cfg_data;
						free_q <= cnt_eff;
					end
					fbpa_pkg::REG_BLOCK_BYTES: begin
						bytes_q <= cfg_data[fbpa_pkg::BYTES_W-1:0];
						free_q  <= cnt_eff;
					end
					fbpa_pkg::REG_BLOCK_COUNT: begin
						count_q <= cfg_data[NW-1:0];
						free_q  <= cnt_new;
					end
					default: begin
					end
				endcase
				head_q <= '0;
				mark_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_SPAN;
					end
				end
				S_SPAN: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					result_q <= '0;
					state_q  <= S_FIN;
					if (op_q == fbpa_pkg::OP_ALLOC) begin
						priority if (free_q == '0) begin
							status_q <= fbpa_pkg::ST_EMPTY;
						end else if (!valid_q || 32'(head_q) >= 32'(cnt_eff)) begin
							status_q <= fbpa_pkg::ST_INVALID;
						end else begin
							state_q <= S_ALLOC;
						end
					end else begin
						priority if (addr_q == '0) begin
							status_q <= fbpa_pkg::ST_NULL;
						end else if (!valid_q || below_q || diff_q >= AW'(span_q) ||
						             free_q >= cnt_eff) begin
							status_q <= fbpa_pkg::ST_INVALID;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_ALLOC: begin
					result_q <= base_q + AW'(prod_q);
					status_q <= fbpa_pkg::ST_OK;
					head_q   <= link_val;
					free_q   <= free_q - NW'(1);
					if (head_q >= mark_q) begin
						mark_q <= head_q + LW'(1);
					end
					state_q  <= S_FIN;
				end
				S_DIV: begin
					cur_q  <= head_q;
					walk_q <= '0;
					if (div_res.done) begin
						if (div_res.rem_zero) begin
							state_q <= S_WALK;
						end else begin
							status_q <= fbpa_pkg::ST_INVALID;
							state_q  <= S_FIN;
						end
					end
				end
				S_WALK: begin
					priority if (walk_q == free_q) begin
						head_q   <= idx_l;
						free_q   <= free_q + NW'(1);
						status_q <= fbpa_pkg::ST_OK;
						state_q  <= S_FIN;
					end else if (32'(cur_q) >= MAX_BLOCKS ||
					             32'(cur_q) == 32'(idx_q)) begin
						status_q <= fbpa_pkg::ST_INVALID;
						state_q  <= S_FIN;
					end else begin
						cur_q  <= cur_next;
						walk_q <= walk_q + NW'(1);
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

FILE: hdl/fbpa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; holds the free-list links of the allocator.
`default_nettype none

module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hdl/fbpa_div.sv
// Iterative restoring divider: one compare and subtract per cycle.
// Splits a pool offset into block index and remainder; uses fbpa_pkg.
`default_nettype none

module fbpa_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [fbpa_pkg::SPAN_W-1:0]  dividend,
	input  wire logic [fbpa_pkg::SIZE_W-1:0]  divisor,
	output fbpa_pkg::div_res_t                res
);

	localparam int SW = fbpa_pkg::SPAN_W;
	localparam int QW = fbpa_pkg::QUOT_W;
	localparam int CW = $clog2(QW + 1);

	logic [SW-1:0] rem_q;
	logic [SW-1:0] dv_q;
	logic [QW-1:0] quot_q;
	logic [CW-1:0] step_q;
	logic          active_q;
	logic          done_q;
	logic          fits;

	assign fits = (rem_q >= dv_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			step_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				step_q   <= '0;
			end else if (active_q) begin
				step_q <= step_q + CW'(1);
				if (step_q == CW'(QW - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dv_q   <= SW'(divisor) << (QW - 1);
			quot_q <= '0;
		end else if (active_q) begin
			if (fits) begin
				rem_q <= rem_q - dv_q;
			end
			quot_q <= {quot_q[QW-2:0], fits};
			dv_q   <= dv_q >> 1;
		end
	end

	assign res.done     = done_q;
	assign res.quot     = quot_q;
	assign res.rem_zero = (rem_q == '0);

endmodule

`default_nettype wire

FILE: tb/tb_fixed_block_pool_allocator_top.sv
// Self-checking testbench for the fixed block pool allocator top level.
// Holds a predictor of the pool and its free list and checks every response.
// Depends on fbpa_pkg and fixed_block_pool_allocator_top.
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator_top;

	localparam logic [fbpa_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int POOL_MAX = 64;
	localparam int ITEM_TARGET = 1850;
	localparam int HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	fbpa_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	fbpa_pkg::rsp_t rsp;
	logic cfg_write = 1'b0;
	logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	fbpa_pkg::req_t request_q[$];
	fbpa_pkg::rsp_t expected_rsp[$];
	fbpa_pkg::rsp_t got_want;
	int errors = 0;
	bit no_idle = 1'b0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;

	logic [31:0] m_base;
	logic [16:0] m_bytes;
	logic [6:0] m_count;
	logic [6:0] m_link [POOL_MAX];
	logic [6:0] m_head;
	logic [6:0] m_free;

	fixed_block_pool_allocator_top #(
		.MAX_BLOCKS(POOL_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pool_blocks();
		return (m_count > 7'd64) ? POOL_MAX : int'(m_count);
	endfunction

	function automatic longint unsigned blk_size();
		return ({47'd0, m_bytes} + 64'd3) & ~64'd3;
	endfunction

	function automatic bit pool_ok();
		longint unsigned sz;
		longint unsigned span;
		sz = blk_size();
		span = sz * pool_blocks();
		if (m_base == 32'd0 || m_base[1:0] != 2'd0 || sz == 0)
			return 1'b0;
		return ({32'd0, m_base} + span) <= 64'hFFFF_FFFF;
	endfunction

	function automatic void rebuild_list();
		for (int i = 0; i < POOL_MAX; i++)
			m_link[i] = 7'(i + 1);
		m_head = '0;
		m_free = 7'(pool_blocks());
	endfunction

	function automatic void apply_reg(logic [fbpa_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
		case (idx)
			fbpa_pkg::REG_POOL_BASE: m_base = data;
			fbpa_pkg::REG_BLOCK_BYTES: m_bytes = data[16:0];
			fbpa_pkg::REG_BLOCK_COUNT: m_count = data[6:0];
			default: return;
		endcase
		rebuild_list();
	endfunction

	function automatic int block_of(logic [31:0] a);
		longint unsigned sz;
		longint unsigned span;
		longint unsigned diff;
		if (!pool_ok())
			return -1;
		sz = blk_size();
		span = sz * pool_blocks();
		if (a < m_base)
			return -1;
		diff = {32'd0, a} - {32'd0, m_base};
		if (diff >= span || diff % sz != 0)
			return -1;
		return int'(diff / sz);
	endfunction

	function automatic bit on_free_list(int idx);
		int cur;
		cur = m_head;
		for (int k = 0; k < m_free && k < POOL_MAX; k++) begin
			if (cur >= POOL_MAX || cur == idx)
				return 1'b1;
			cur = m_link[cur];
		end
		return 1'b0;
	endfunction

	function automatic fbpa_pkg::rsp_t pool_predict(fbpa_pkg::req_t r);
		fbpa_pkg::rsp_t o;
		int idx;
		o = '0;
		o.status = fbpa_pkg::ST_OK;
		if (r.operation == fbpa_pkg::OP_ALLOC) begin
			if (m_free == 0) begin
				o.status = fbpa_pkg::ST_EMPTY;
			end else if (!pool_ok() || m_head >= pool_blocks()) begin
				o.status = fbpa_pkg::ST_INVALID;
			end else begin
				o.block_address = 32'({32'd0, m_base} + m_head * blk_size());
				m_head = m_link[m_head];
				m_free--;
			end
		end else if (r.address == '0) begin
			o.status = fbpa_pkg::ST_NULL;
		end else begin
			idx = block_of(r.address);
			if (idx < 0 || m_free >= pool_blocks() || on_free_list(idx)) begin
				o.status = fbpa_pkg::ST_INVALID;
			end else begin
				m_link[idx] = m_head;
				m_head = 7'(idx);
				m_free++;
			end
		end
		o.free_blocks = m_free;
		return o;
	endfunction

	function automatic void queue_req(logic op, logic [31:0] a);
		fbpa_pkg::req_t r;
		r.operation = op;
		r.address = a;
		request_q.push_back(r);
	endfunction

	function automatic fbpa_pkg::req_t random_req(int alloc_pct);
		fbpa_pkg::req_t r;
		longint unsigned sz;
		longint unsigned idx;
		int pick;
		sz = blk_size();
		r.operation = ($urandom_range(99) < alloc_pct) ? fbpa_pkg::OP_ALLOC
		                                               : fbpa_pkg::OP_FREE;
		r.address = $urandom;
		pick = $urandom_range(99);
		idx = $urandom_range((pool_blocks() > 0) ? pool_blocks() - 1 : 0);
		if (r.operation == fbpa_pkg::OP_FREE) begin
			if (pick < 70)
				r.address = 32'({32'd0, m_base} + idx * sz);
			else if (pick < 78)
				r.address = '0;
			else if (pick < 84)
				r.address = 32'({32'd0, m_base} + idx * sz + $urandom_range(1, 3));
			else if (pick < 90)
				r.address = 32'({32'd0, m_base} + pool_blocks() * sz);
		end
		return r;
	endfunction

	task automatic drain();
		do
			@(negedge clk);
		while (request_q.size() != 0 || req_valid || expected_rsp.size() != 0);
	endtask

	task automatic put_reg(logic [fbpa_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		apply_reg(idx, data);
	endtask

	task automatic write_pool(logic [31:0] base, logic [31:0] bytes, logic [31:0] count);
		drain();
		put_reg(fbpa_pkg::REG_POOL_BASE, base);
		put_reg(fbpa_pkg::REG_BLOCK_BYTES, bytes);
		put_reg(fbpa_pkg::REG_BLOCK_COUNT, count);
		@(posedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else if (!req_valid || !req_stall) begin
			if (req_valid)
				expected_rsp.push_back(pool_predict(req));
			if (request_q.size() != 0 && (no_idle || $urandom_range(99) >= 24)) begin
				req_valid <= 1'b1;
				req <= request_q.pop_front();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (hold_left != 0 || hold_req != hold_ack) begin
			if (hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_ack = hold_req;
			end
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= !no_idle && $urandom_range(99) < 24;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				$error("response with no request outstanding: status %0d address %0h",
					rsp.status, rsp.block_address);
				errors++;
			end else begin
				got_want = expected_rsp.pop_front();
				if (rsp.status !== got_want.status) begin
					$error("status expected %0d actual %0d", got_want.status, rsp.status);
					errors++;
				end
				if (rsp.block_address !== got_want.block_address) begin
					$error("block_address expected %0h actual %0h",
						got_want.block_address, rsp.block_address);
					errors++;
				end
				if (rsp.free_blocks !== got_want.free_blocks) begin
					$error("free_blocks expected %0d actual %0d",
						got_want.free_blocks, rsp.free_blocks);
					errors++;
				end
			end
		end
	end

	initial begin
		#30_000_000;
		$display("fixed_block_pool_allocator_top verification failed");
		$finish;
	end

	initial begin
		int sel;
		int n;
		int pct;
		int sent;
		int phase;
		logic [31:0] base;
		logic [31:0] bytes;
		logic [31:0] count;
		longint unsigned span;

		m_base = fbpa_pkg::RST_POOL_BASE;
		m_bytes = fbpa_pkg::RST_BLOCK_BYTES;
		m_count = fbpa_pkg::RST_BLOCK_COUNT;
		rebuild_list();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The pool after reset has a zero base and is therefore unusable.
		queue_req(fbpa_pkg::OP_ALLOC, 32'h0);
		queue_req(fbpa_pkg::OP_FREE, 32'h0);
		queue_req(fbpa_pkg::OP_FREE, 32'hFFFF_FFFF);

		write_pool(32'h1000, 32'd5, 32'd3);
		repeat (4) queue_req(fbpa_pkg::OP_ALLOC, 32'hFFFF_FFFF);
		queue_req(fbpa_pkg::OP_FREE, 32'h1008);
		queue_req(fbpa_pkg::OP_FREE, 32'h1008);
		queue_req(fbpa_pkg::OP_FREE, 32'h1004);
		queue_req(fbpa_pkg::OP_FREE, 32'h1018);
		drain();
		put_reg(REG_SPARE, 32'hFFFF_FFFF);
		@(posedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
		queue_req(fbpa_pkg::OP_FREE, 32'h1000);
		queue_req(fbpa_pkg::OP_FREE, 32'h1010);
		queue_req(fbpa_pkg::OP_FREE, 32'h1010);

		write_pool(32'h1000, 32'd5, 32'd0);
		queue_req(fbpa_pkg::OP_ALLOC, 32'h0);
		queue_req(fbpa_pkg::OP_FREE, 32'h0);
		queue_req(fbpa_pkg::OP_FREE, 32'h1000);

		write_pool(32'hFFFF_FFF8, 32'd4, 32'd1);
		queue_req(fbpa_pkg::OP_ALLOC, 32'h0);
		write_pool(32'hFFFF_FFFC, 32'd4, 32'd1);
		queue_req(fbpa_pkg::OP_ALLOC, 32'h0);
		write_pool(32'h1002, 32'd4, 32'd2);
		queue_req(fbpa_pkg::OP_ALLOC, 32'h0);
		write_pool(32'h2000, 32'd0, 32'd127);
		queue_req(fbpa_pkg::OP_ALLOC, 32'h0);
		write_pool(32'h100, 32'd131071, 32'd127);
		queue_req(fbpa_pkg::OP_ALLOC, 32'h0);
		queue_req(fbpa_pkg::OP_FREE, 32'h100 + 32'h2_0000 * 63);

		sent = 0;
		phase = 0;
		while (sent < ITEM_TARGET) begin
			sel = $urandom_range(19);
			count = (sel < 12) ? $urandom_range(1, 8) : (sel < 15) ? 32'd64 :
				(sel < 16) ? 32'd0 : (sel < 17) ? 32'd127 : $urandom_range(1, 127);
			sel = $urandom_range(19);
			bytes = (sel < 12) ? $urandom_range(1, 64) : (sel < 14) ? 32'd65536 :
				(sel < 15) ? 32'd131071 : (sel < 16) ? 32'd0 : $urandom_range(1, 131071);
			span = ({32'd0, bytes} + 64'd3) & ~64'd3;
			span = span * ((count > 64) ? 64 : count);
			sel = $urandom_range(19);
			if (sel < 14)
				base = $urandom_range(1, 32'h0FFF_FFFF) << 2;
			else if (sel < 17)
				base = 32'(64'h1_0000_0000 - span - 64'd4 * $urandom_range(0, 1));
			else if (sel < 18)
				base = ($urandom & 32'hFFFF_FFFC) | $urandom_range(1, 3);
			else if (sel < 19)
				base = 32'h0;
			else
				base = $urandom;
			write_pool(base, bytes, count);
			no_idle = (phase >= 8 && phase < 12);
			n = $urandom_range(30, 70);
			pct = $urandom_range(35, 65);
			for (int i = 0; i < n; i++) begin
				if (phase == 5 && i == n / 2)
					drain();
				request_q.push_back(random_req(pct));
			end
			if (phase == 3)
				hold_req++;
			sent += n;
			phase++;
		end

		no_idle = 1'b0;
		drain();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("fixed_block_pool_allocator_top verification clean");
		else
			$display("fixed_block_pool_allocator_top verification failed");
		$finish;
	end

endmodule

FILE: sim.f
hdl/fbpa_pkg.sv
hdl/fbpa_ram.sv
hdl/fbpa_div.sv
hdl/fixed_block_pool_allocator_top.sv
tb/tb_fixed_block_pool_allocator_top.sv
